// ----- src/amb_pkg.sv -----
// ----------------------------------------------------------------------------
// amb_pkg: shared definitions for the main bus decoder
// Address map constants, access kinds, memory request and response words.
// ----------------------------------------------------------------------------
package amb_pkg;

  localparam int unsigned BANK_COUNT_DEF = 4;
  localparam int unsigned FIXED_SIZE     = 32'h8000;
  localparam int unsigned PAGE_SIZE      = 32'h4000;
  localparam int unsigned ROM_ADDR_W     = 17;
  localparam int unsigned PAGE_AW        = 14;

  localparam int unsigned VRAM_DEPTH = 2048;
  localparam int unsigned WRAM_DEPTH = 8192;
  localparam int unsigned VRAM_AW    = $clog2(VRAM_DEPTH);
  localparam int unsigned WRAM_AW    = $clog2(WRAM_DEPTH);

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_ONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_TWO = 1'b1;

  localparam logic [7:0] DIP_ONE_RESET = 8'hf7;
  localparam logic [7:0] DIP_TWO_RESET = 8'hff;
  localparam logic [7:0] VBLANK_MASK   = 8'h08;

  localparam logic [15:0] ADDR_SYSTEM     = 16'hc000;
  localparam logic [15:0] ADDR_PLAYER_ONE = 16'hc001;
  localparam logic [15:0] ADDR_PLAYER_TWO = 16'hc002;
  localparam logic [15:0] ADDR_DIP_ONE    = 16'hc003;
  localparam logic [15:0] ADDR_DIP_TWO    = 16'hc004;
  localparam logic [15:0] ADDR_TABLE      = 16'hc4c9;
  localparam logic [15:0] ADDR_SOUND      = 16'hc800;
  localparam logic [15:0] ADDR_CONTROL    = 16'hc804;
  localparam logic [15:0] ADDR_SCROLL_XLO = 16'hd800;
  localparam logic [15:0] ADDR_SCROLL_XHI = 16'hd801;
  localparam logic [15:0] ADDR_SCROLL_Y   = 16'hd802;
  localparam logic [15:0] ADDR_LAYER      = 16'hd806;
  localparam logic [4:0]  VRAM_PAGE       = 5'b11010;
  localparam logic [2:0]  WRAM_PAGE       = 3'b111;
  localparam logic [1:0]  BANK_WINDOW     = 2'b10;

  localparam int unsigned TABLE_LEN = 3;
  localparam logic [7:0] FIXED_TABLE [TABLE_LEN] = '{8'hff, 8'h00, 8'h00};

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LOAD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RSEL_DIRECT = 2'd0,
    RSEL_ROM    = 2'd1,
    RSEL_VRAM   = 2'd2,
    RSEL_WRAM   = 2'd3
  } rsel_t;

  typedef struct packed {
    logic                  rom_re;
    logic                  rom_we;
    logic [ROM_ADDR_W-1:0] rom_addr;
    logic                  vram_re;
    logic                  vram_we;
    logic [VRAM_AW-1:0]    vram_addr;
    logic                  wram_re;
    logic                  wram_we;
    logic [WRAM_AW-1:0]    wram_addr;
    logic [7:0]            wdata;
  } mem_req_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] rom;
    logic [7:0] vram;
    logic [7:0] wram;
  } mem_rsp_t;

endpackage

// ----- src/amb_if.sv -----
// ----------------------------------------------------------------------------
// amb_if: bus access and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface amb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [16:0] address;
  logic [7:0]  write_data;
  logic [7:0]  system_in;
  logic [7:0]  player_one_in;
  logic [7:0]  player_two_in;
  logic        vblank;

  modport source (
    output valid, kind, address, write_data, system_in, player_one_in,
           player_two_in, vblank,
    input  ready
  );
  modport sink (
    input  valid, kind, address, write_data, system_in, player_one_in,
           player_two_in, vblank,
    output ready
  );
endinterface

interface amb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [1:0]  rom_bank;
  logic [15:0] scroll_x;
  logic [7:0]  scroll_y;
  logic [7:0]  sound_latch;
  logic [1:0]  coin_counters;
  logic        sound_reset;
  logic        flip_screen;
  logic        char_enable;
  logic [2:0]  sprite_bank;
  logic        bg_enable;
  logic        obj_enable;

  modport source (
    output valid, read_data, rom_bank, scroll_x, scroll_y, sound_latch,
           coin_counters, sound_reset, flip_screen, char_enable, sprite_bank,
           bg_enable, obj_enable,
    input  ready
  );
  modport sink (
    input  valid, read_data, rom_bank, scroll_x, scroll_y, sound_latch,
           coin_counters, sound_reset, flip_screen, char_enable, sprite_bank,
           bg_enable, obj_enable,
    output ready
  );
endinterface

// ----- src/amb_store.sv -----
// ----------------------------------------------------------------------------
// amb_store: ROM image, video RAM and work RAM
// Synchronous memories with registered reads and a clearing sweep of both
// RAMs after reset.
// ----------------------------------------------------------------------------
module amb_store #(
  parameter int unsigned BANK_COUNT = amb_pkg::BANK_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  amb_pkg::mem_req_t req,
  output amb_pkg::mem_rsp_t rsp
);
  import amb_pkg::*;

  localparam int unsigned ROM_DEPTH = FIXED_SIZE + BANK_COUNT * PAGE_SIZE;
  localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);

  logic [7:0] rom_mem  [ROM_DEPTH];
  logic [7:0] vram_mem [VRAM_DEPTH];
  logic [7:0] wram_mem [WRAM_DEPTH];

  logic               clr_active_r;
  logic [WRAM_AW-1:0] clr_idx_r;
  logic [7:0]         rom_rd_r;
  logic [7:0]         vram_rd_r;
  logic [7:0]         wram_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == WRAM_AW'(WRAM_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rom_we) begin
      rom_mem[req.rom_addr[ROM_AW-1:0]] <= req.wdata;
    end
    if (req.rom_re) begin
      rom_rd_r <= rom_mem[req.rom_addr[ROM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      if (clr_idx_r[WRAM_AW-1:VRAM_AW] == '0) begin
        vram_mem[clr_idx_r[VRAM_AW-1:0]] <= 8'h00;
      end
    end else if (req.vram_we) begin
      vram_mem[req.vram_addr] <= req.wdata;
    end
    if (req.vram_re) begin
      vram_rd_r <= vram_mem[req.vram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      wram_mem[clr_idx_r] <= 8'h00;
    end else if (req.wram_we) begin
      wram_mem[req.wram_addr] <= req.wdata;
    end
    if (req.wram_re) begin
      wram_rd_r <= wram_mem[req.wram_addr];
    end
  end

  assign rsp.busy = clr_active_r;
  assign rsp.rom  = rom_rd_r;
  assign rsp.vram = vram_rd_r;
  assign rsp.wram = wram_rd_r;

endmodule

// ----- src/arcade_main_bus_decoder.sv -----
// ----------------------------------------------------------------------------
// arcade_main_bus_decoder: main CPU memory-map decoder
// Pipeline: an accepted access passes the memory read stage, then the output
// register, to its result word. Throughput: one access per cycle while results
// are taken and no reset sweep runs, set by the single port of each memory.
// Reset: clears latches and sweeps work RAM and video RAM with in_bus.ready low; ROM is never cleared.
// ----------------------------------------------------------------------------
module arcade_main_bus_decoder #(
  parameter int unsigned BANK_COUNT = amb_pkg::BANK_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  amb_in_if.sink                        in_bus,
  amb_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [amb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import amb_pkg::*;

  localparam int unsigned ROM_DEPTH = FIXED_SIZE + BANK_COUNT * PAGE_SIZE;
  localparam logic [ROM_ADDR_W-1:0] ROM_LIMIT  = ROM_ADDR_W'(ROM_DEPTH);
  localparam logic [ROM_ADDR_W-1:0] FIXED_BASE = ROM_ADDR_W'(FIXED_SIZE);
  localparam logic [2:0]            BANK_CNT3  = 3'(BANK_COUNT);
  localparam logic [15:0]           TABLE_END  = ADDR_TABLE + 16'(TABLE_LEN);

  mem_req_t req;
  mem_rsp_t rsp;

  logic        accept;
  logic        s1_move;
  logic [15:0] addr16;
  logic [2:0]  bank_raw;
  logic [1:0]  bank_wrap;
  logic [ROM_ADDR_W-1:0] bank_addr;
  logic [7:0]  rdata;

  logic [7:0]  dip_one_r;
  logic [7:0]  dip_two_r;
  logic [1:0]  bank_r,      bank_nxt;
  logic [7:0]  control_r,   control_nxt;
  logic [7:0]  layer_r,     layer_nxt;
  logic [7:0]  sound_r,     sound_nxt;
  logic [15:0] scroll_x_r,  scroll_x_nxt;
  logic [7:0]  scroll_y_r,  scroll_y_nxt;

  logic        s1_valid_r;
  rsel_t       s1_rsel_r,   s1_rsel_nxt;
  logic [7:0]  s1_direct_r, s1_direct_nxt;

  logic        out_valid_r;
  logic [7:0]  out_rdata_r;
  logic [1:0]  out_bank_r;
  logic [15:0] out_scroll_x_r;
  logic [7:0]  out_scroll_y_r;
  logic [7:0]  out_sound_r;
  logic [7:0]  out_control_r;
  logic [7:0]  out_layer_r;

  amb_store #(.BANK_COUNT(BANK_COUNT)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign s1_move      = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !rsp.busy && (!s1_valid_r || s1_move);
  assign accept       = in_bus.valid && in_bus.ready;
  assign addr16       = in_bus.address[15:0];

  assign bank_raw  = {1'b0, in_bus.write_data[3:2]};
  assign bank_wrap = (BANK_COUNT == 1)     ? 2'd0 :
                     (bank_raw >= BANK_CNT3) ? 2'(bank_raw - BANK_CNT3) :
                     bank_raw[1:0];
  assign bank_addr = FIXED_BASE + {1'b0, bank_r, {PAGE_AW{1'b0}}}
                   + {3'b000, addr16[PAGE_AW-1:0]};

  always_comb begin
    req           = '0;
    req.wdata     = in_bus.write_data;
    s1_rsel_nxt   = RSEL_DIRECT;
    s1_direct_nxt = 8'h00;
    bank_nxt      = bank_r;
    control_nxt   = control_r;
    layer_nxt     = layer_r;
    sound_nxt     = sound_r;
    scroll_x_nxt  = scroll_x_r;
    scroll_y_nxt  = scroll_y_r;
    if (accept) begin
      unique case (in_bus.kind)
        KIND_READ: begin
          priority if (!addr16[15]) begin
            req.rom_re   = 1'b1;
            req.rom_addr = {2'b00, addr16[14:0]};
            s1_rsel_nxt  = RSEL_ROM;
          end else if (addr16[15:14] == BANK_WINDOW) begin
            req.rom_re   = 1'b1;
            req.rom_addr = bank_addr;
            s1_rsel_nxt  = RSEL_ROM;
          end else if (addr16 == ADDR_SYSTEM) begin
            s1_direct_nxt = in_bus.vblank ? (in_bus.system_in & ~VBLANK_MASK)
                                          : (in_bus.system_in | VBLANK_MASK);
          end else if (addr16 == ADDR_PLAYER_ONE) begin
            s1_direct_nxt = in_bus.player_one_in;
          end else if (addr16 == ADDR_PLAYER_TWO) begin
            s1_direct_nxt = in_bus.player_two_in;
          end else if (addr16 == ADDR_DIP_ONE) begin
            s1_direct_nxt = dip_one_r;
          end else if (addr16 == ADDR_DIP_TWO) begin
            s1_direct_nxt = dip_two_r;
          end else if (addr16 >= ADDR_TABLE && addr16 < TABLE_END) begin
            s1_direct_nxt = FIXED_TABLE[2'(addr16 - ADDR_TABLE)];
          end else if (addr16[15:11] == VRAM_PAGE) begin
            req.vram_re   = 1'b1;
            req.vram_addr = addr16[VRAM_AW-1:0];
            s1_rsel_nxt   = RSEL_VRAM;
          end else if (addr16[15:13] == WRAM_PAGE) begin
            req.wram_re   = 1'b1;
            req.wram_addr = addr16[WRAM_AW-1:0];
            s1_rsel_nxt   = RSEL_WRAM;
          end else begin
            s1_direct_nxt = 8'h00;
          end
        end
        KIND_WRITE: begin
          priority if (addr16 == ADDR_SOUND) begin
            sound_nxt = in_bus.write_data;
          end else if (addr16 == ADDR_CONTROL) begin
            control_nxt = in_bus.write_data;
            bank_nxt    = bank_wrap;
          end else if (addr16 == ADDR_SCROLL_XLO) begin
            scroll_x_nxt = {scroll_x_r[15:8], in_bus.write_data};
          end else if (addr16 == ADDR_SCROLL_XHI) begin
            scroll_x_nxt = {in_bus.write_data, scroll_x_r[7:0]};
          end else if (addr16 == ADDR_SCROLL_Y) begin
            scroll_y_nxt = in_bus.write_data;
          end else if (addr16 == ADDR_LAYER) begin
            layer_nxt = in_bus.write_data;
          end else if (addr16[15:11] == VRAM_PAGE) begin
            req.vram_we   = 1'b1;
            req.vram_addr = addr16[VRAM_AW-1:0];
          end else if (addr16[15:13] == WRAM_PAGE) begin
            req.wram_we   = 1'b1;
            req.wram_addr = addr16[WRAM_AW-1:0];
          end else begin
            req.wram_we = 1'b0;
          end
        end
        KIND_LOAD: begin
          if (in_bus.address < ROM_LIMIT) begin
            req.rom_we   = 1'b1;
            req.rom_addr = in_bus.address;
          end
        end
        default: begin
          s1_direct_nxt = 8'h00;
        end
      endcase
    end
  end

  always_comb begin
    unique case (s1_rsel_r)
      RSEL_ROM:  rdata = rsp.rom;
      RSEL_VRAM: rdata = rsp.vram;
      RSEL_WRAM: rdata = rsp.wram;
      default:   rdata = s1_direct_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dip_one_r   <= DIP_ONE_RESET;
      dip_two_r   <= DIP_TWO_RESET;
      bank_r      <= '0;
      control_r   <= '0;
      layer_r     <= '0;
      sound_r     <= '0;
      scroll_x_r  <= '0;
      scroll_y_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DIP_ONE: dip_one_r <= cfg_data;
          CFG_DIP_TWO: dip_two_r <= cfg_data;
          default:     dip_one_r <= dip_one_r;
        endcase
      end
      bank_r     <= bank_nxt;
      control_r  <= control_nxt;
      layer_r    <= layer_nxt;
      sound_r    <= sound_nxt;
      scroll_x_r <= scroll_x_nxt;
      scroll_y_r <= scroll_y_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rsel_r   <= s1_rsel_nxt;
      s1_direct_r <= s1_direct_nxt;
    end
    if (s1_move) begin
      out_rdata_r    <= rdata;
      out_bank_r     <= bank_r;
      out_scroll_x_r <= scroll_x_r;
      out_scroll_y_r <= scroll_y_r;
      out_sound_r    <= sound_r;
      out_control_r  <= control_r;
      out_layer_r    <= layer_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.read_data     = out_rdata_r;
  assign out_bus.rom_bank      = out_bank_r;
  assign out_bus.scroll_x      = out_scroll_x_r;
  assign out_bus.scroll_y      = out_scroll_y_r;
  assign out_bus.sound_latch   = out_sound_r;
  assign out_bus.coin_counters = out_control_r[1:0];
  assign out_bus.sound_reset   = out_control_r[5];
  assign out_bus.flip_screen   = out_control_r[6];
  assign out_bus.char_enable   = out_control_r[7];
  assign out_bus.sprite_bank   = out_layer_r[2:0];
  assign out_bus.bg_enable     = out_layer_r[4];
  assign out_bus.obj_enable    = out_layer_r[5];

endmodule

// ----- src/amb_checker.sv -----
// ----------------------------------------------------------------------------
// amb_checker: port-level checks for the main bus decoder
// Reset sweep, output hold, bank range and pipeline back-pressure.
// ----------------------------------------------------------------------------
module amb_checker #(
  parameter int unsigned BANK_COUNT = amb_pkg::BANK_COUNT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_data,
  input logic [1:0]  out_rom_bank,
  input logic [15:0] out_scroll_x
);

  a_reset_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
                                && $stable(out_scroll_x))
    else $error("stalled result word changed");

  a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_rom_bank} < 3'(BANK_COUNT)))
    else $error("rom bank beyond bank count");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid && !out_ready |=> out_ready || !in_ready)
    else $error("input taken with both stages full");

endmodule

bind arcade_main_bus_decoder amb_checker #(.BANK_COUNT(BANK_COUNT)) u_amb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_read_data (out_bus.read_data),
  .out_rom_bank  (out_bus.rom_bank),
  .out_scroll_x  (out_bus.scroll_x)
);

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: main bus decoder check
// Drives CPU reads, CPU writes, ROM image loads and unknown accesses through
// the valid/ready input channel, keeps its own copy of the memory map and
// latches, and compares every result word field by field in order. Dip
// switches are rewritten between phases; ROM is only read where loaded.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import amb_pkg::*;

  localparam int unsigned ROM_BYTES    = FIXED_SIZE + BANK_COUNT_DEF * PAGE_SIZE;
  localparam logic [1:0]  KIND_UNKNOWN = 2'd3;
  localparam logic [15:0] LATCH_ADDRS [6] = '{ADDR_SOUND, ADDR_CONTROL, ADDR_SCROLL_XLO,
                                              ADDR_SCROLL_XHI, ADDR_SCROLL_Y, ADDR_LAYER};

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] address;
    logic [7:0]  write_data;
    logic [7:0]  system_in;
    logic [7:0]  player_one_in;
    logic [7:0]  player_two_in;
    logic        vblank;
  } access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  rom_bank;
    logic [15:0] scroll_x;
    logic [7:0]  scroll_y;
    logic [7:0]  sound_latch;
    logic [1:0]  coin_counters;
    logic        sound_reset;
    logic        flip_screen;
    logic        char_enable;
    logic [2:0]  sprite_bank;
    logic        bg_enable;
    logic        obj_enable;
  } result_t;

  class bus_state_tracker;
    bit [7:0]  rom_image [ROM_BYTES];
    bit [7:0]  vram [VRAM_DEPTH];
    bit [7:0]  wram [WRAM_DEPTH];
    bit [1:0]  bank;
    bit [7:0]  control;
    bit [7:0]  layer;
    bit [7:0]  sound;
    bit [15:0] scroll_x;
    bit [7:0]  scroll_y;
    bit [7:0]  dip_one;
    bit [7:0]  dip_two;
    result_t   expected_words [$];
    int        errors;

    function new();
      dip_one = DIP_ONE_RESET;
      dip_two = DIP_TWO_RESET;
      errors  = 0;
    endfunction

    function void set_dip(logic [CFG_IDX_W-1:0] idx, bit [7:0] value);
      if (idx == CFG_DIP_ONE) dip_one = value;
      else dip_two = value;
    endfunction

    function bit [7:0] read_byte(access_t a);
      bit [15:0]   addr;
      int unsigned idx;
      addr = a.address[15:0];
      if (addr < FIXED_SIZE) return rom_image[addr];
      if (addr < 16'hc000) begin
        idx = FIXED_SIZE + bank * PAGE_SIZE + addr[PAGE_AW-1:0];
        return rom_image[idx];
      end
      case (addr)
        ADDR_SYSTEM:     return a.vblank ? (a.system_in & ~VBLANK_MASK)
                                         : (a.system_in | VBLANK_MASK);
        ADDR_PLAYER_ONE: return a.player_one_in;
        ADDR_PLAYER_TWO: return a.player_two_in;
        ADDR_DIP_ONE:    return dip_one;
        ADDR_DIP_TWO:    return dip_two;
        default: ;
      endcase
      if (addr >= ADDR_TABLE && addr < ADDR_TABLE + TABLE_LEN)
        return FIXED_TABLE[addr - ADDR_TABLE];
      if (addr[15:11] == VRAM_PAGE) return vram[addr[VRAM_AW-1:0]];
      if (addr[15:13] == WRAM_PAGE) return wram[addr[WRAM_AW-1:0]];
      return 8'h00;
    endfunction

    function void write_byte(bit [15:0] addr, bit [7:0] value);
      if (addr < 16'hc000) return;
      case (addr)
        ADDR_SOUND:      sound = value;
        ADDR_CONTROL: begin
          control = value;
          bank    = value[3:2] % BANK_COUNT_DEF;
        end
        ADDR_SCROLL_XLO: scroll_x[7:0] = value;
        ADDR_SCROLL_XHI: scroll_x[15:8] = value;
        ADDR_SCROLL_Y:   scroll_y = value;
        ADDR_LAYER:      layer = value;
        default: begin
          if (addr[15:11] == VRAM_PAGE) vram[addr[VRAM_AW-1:0]] = value;
          else if (addr[15:13] == WRAM_PAGE) wram[addr[WRAM_AW-1:0]] = value;
        end
      endcase
    endfunction

    function void note_access(access_t a);
      result_t r;
      r = '0;
      case (a.kind)
        KIND_READ:  r.read_data = read_byte(a);
        KIND_WRITE: write_byte(a.address[15:0], a.write_data);
        KIND_LOAD:  if (a.address < ROM_BYTES) rom_image[a.address] = a.write_data;
        default: ;
      endcase
      r.rom_bank      = bank;
      r.scroll_x      = scroll_x;
      r.scroll_y      = scroll_y;
      r.sound_latch   = sound;
      r.coin_counters = control[1:0];
      r.sound_reset   = control[5];
      r.flip_screen   = control[6];
      r.char_enable   = control[7];
      r.sprite_bank   = layer[2:0];
      r.bg_enable     = layer[4];
      r.obj_enable    = layer[5];
      expected_words.push_back(r);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing, actual 0x%0h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare("read_data", want.read_data, got.read_data);
      compare("rom_bank", want.rom_bank, got.rom_bank);
      compare("scroll_x", want.scroll_x, got.scroll_x);
      compare("scroll_y", want.scroll_y, got.scroll_y);
      compare("sound_latch", want.sound_latch, got.sound_latch);
      compare("coin_counters", want.coin_counters, got.coin_counters);
      compare("sound_reset", want.sound_reset, got.sound_reset);
      compare("flip_screen", want.flip_screen, got.flip_screen);
      compare("char_enable", want.char_enable, got.char_enable);
      compare("sprite_bank", want.sprite_bank, got.sprite_bank);
      compare("bg_enable", want.bg_enable, got.bg_enable);
      compare("obj_enable", want.obj_enable, got.obj_enable);
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]      cfg_data;

  amb_in_if  in_bus ();
  amb_out_if out_bus ();

  arcade_main_bus_decoder #(.BANK_COUNT(BANK_COUNT_DEF)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bus_state_tracker tracker;
  bit               rom_loaded [ROM_BYTES];
  int unsigned      loaded_offsets [$];
  bit [1:0]         gen_bank;
  bit               calm;
  int               results_seen;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[arcade_main_bus_decoder] ERROR");
    $finish;
  end

  // build one access; track loaded ROM and the bank as the sequence will leave them
  function automatic access_t make_access(logic [1:0] kind, logic [16:0] address,
                                          logic [7:0] data);
    access_t a;
    a.kind          = kind;
    a.address       = address;
    a.write_data    = data;
    a.system_in     = $urandom;
    a.player_one_in = $urandom;
    a.player_two_in = $urandom;
    a.vblank        = $urandom_range(0, 1);
    if (kind == KIND_LOAD && address < ROM_BYTES && !rom_loaded[address]) begin
      rom_loaded[address] = 1'b1;
      loaded_offsets.push_back(address);
    end
    if (kind == KIND_WRITE && address[15:0] == ADDR_CONTROL) gen_bank = data[3:2];
    return a;
  endfunction

  function automatic int pick_rom_address();
    int unsigned off;
    for (int i = 0; i < 4; i++) begin
      if (loaded_offsets.size() == 0) return -1;
      off = loaded_offsets[$urandom_range(0, loaded_offsets.size() - 1)];
      if (off < FIXED_SIZE) return off;
      if ((off - FIXED_SIZE) / PAGE_SIZE == gen_bank)
        return 32'h8000 | (off % PAGE_SIZE);
    end
    return -1;
  endfunction

  function automatic logic [15:0] pick_ram_address(bit video);
    int unsigned span;
    span = video ? VRAM_DEPTH : WRAM_DEPTH;
    case ($urandom_range(0, 3))
      0:       return (video ? 16'hd000 : 16'he000) + $urandom_range(0, span - 1);
      1:       return (video ? 16'hd000 : 16'he000) + span - 1 - $urandom_range(0, 15);
      default: return (video ? 16'hd000 : 16'he000) + $urandom_range(0, 31);
    endcase
  endfunction

  function automatic access_t random_access();
    int          sel;
    int          r;
    int          rom_addr;
    logic [15:0] addr;
    logic [16:0] offset;
    sel = $urandom_range(0, 99);
    r   = $urandom_range(0, 9);
    if (sel < 15) begin
      if (r < 6)
        offset = FIXED_SIZE + $urandom_range(0, 3) * PAGE_SIZE + $urandom_range(0, 63);
      else if (r < 8) offset = $urandom_range(0, 63);
      else offset = $urandom_range(0, 17'h1ffff);
      return make_access(KIND_LOAD, offset, $urandom);
    end
    if (sel < 18) return make_access(KIND_UNKNOWN, $urandom_range(0, 17'h1ffff), $urandom);
    if (sel < 50) begin
      if (r < 4) addr = LATCH_ADDRS[$urandom_range(0, 5)];
      else if (r < 6) addr = pick_ram_address(1'b1);
      else if (r < 8) addr = pick_ram_address(1'b0);
      else if (r < 9) addr = $urandom_range(0, 16'hbfff);
      else addr = 16'hc000 | $urandom_range(0, 16'h3fff);
      return make_access(KIND_WRITE, {1'($urandom_range(0, 1)), addr}, $urandom);
    end
    if (r < 3) begin
      rom_addr = pick_rom_address();
      addr = (rom_addr < 0) ? pick_ram_address(1'b1) : rom_addr[15:0];
    end else if (r < 4) addr = ADDR_SYSTEM + $urandom_range(0, 4);
    else if (r < 5) addr = ADDR_TABLE - 1 + $urandom_range(0, 4);
    else if (r < 7) addr = pick_ram_address(1'b1);
    else if (r < 9) addr = pick_ram_address(1'b0);
    else addr = 16'hc000 | $urandom_range(0, 16'h3fff);
    return make_access(KIND_READ, {1'($urandom_range(0, 1)), addr}, $urandom);
  endfunction

  task automatic send_access(access_t a);
    in_bus.valid         <= 1'b1;
    in_bus.kind          <= a.kind;
    in_bus.address       <= a.address;
    in_bus.write_data    <= a.write_data;
    in_bus.system_in     <= a.system_in;
    in_bus.player_one_in <= a.player_one_in;
    in_bus.player_two_in <= a.player_two_in;
    in_bus.vblank        <= a.vblank;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    tracker.note_access(a);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic issue(logic [1:0] kind, logic [16:0] address, logic [7:0] data);
    send_access(make_access(kind, address, data));
  endtask

  task automatic run_directed();
    access_t a;
    issue(KIND_LOAD, 17'h00000, 8'ha5);
    issue(KIND_LOAD, 17'h17fff, 8'h3c);
    issue(KIND_LOAD, 17'h18000, 8'h77);
    issue(KIND_READ, 17'h10000, 8'h00);
    issue(KIND_WRITE, {1'b0, ADDR_CONTROL}, 8'hff);
    issue(KIND_READ, 17'h0bfff, 8'h00);
    issue(KIND_WRITE, {1'b1, ADDR_CONTROL}, 8'h00);
    a = make_access(KIND_READ, {1'b0, ADDR_SYSTEM}, 8'h00);
    a.system_in = 8'hff;
    a.vblank    = 1'b1;
    send_access(a);
    a = make_access(KIND_READ, {1'b0, ADDR_SYSTEM}, 8'h00);
    a.system_in = 8'h00;
    a.vblank    = 1'b0;
    send_access(a);
    issue(KIND_READ, {1'b0, ADDR_PLAYER_ONE}, 8'h00);
    issue(KIND_READ, {1'b0, ADDR_PLAYER_TWO}, 8'h00);
    issue(KIND_READ, {1'b0, ADDR_DIP_ONE}, 8'h00);
    issue(KIND_READ, {1'b0, ADDR_DIP_TWO}, 8'h00);
    issue(KIND_READ, {1'b0, ADDR_TABLE}, 8'h00);
    issue(KIND_READ, {1'b0, ADDR_TABLE + 16'd2}, 8'h00);
    issue(KIND_WRITE, {1'b0, ADDR_SCROLL_XLO}, 8'hff);
    issue(KIND_WRITE, {1'b0, ADDR_SCROLL_XHI}, 8'hff);
    issue(KIND_WRITE, {1'b0, ADDR_SCROLL_Y}, 8'hff);
    issue(KIND_WRITE, {1'b0, ADDR_LAYER}, 8'hff);
    issue(KIND_WRITE, {1'b0, ADDR_SOUND}, 8'hff);
    issue(KIND_WRITE, 17'h0d7ff, 8'h81);
    issue(KIND_READ, 17'h0d7ff, 8'h00);
    issue(KIND_WRITE, 17'h0ffff, 8'h42);
    issue(KIND_READ, 17'h1ffff, 8'h00);
    issue(KIND_WRITE, 17'h07fff, 8'h99);
    issue(KIND_UNKNOWN, {1'b0, ADDR_SOUND}, 8'h55);
    issue(KIND_READ, {1'b0, ADDR_SOUND}, 8'h00);
    in_bus.valid <= 1'b0;
  endtask

  task automatic run_stream(int count, bit calm_tail);
    for (int i = 0; i < count; i++) begin
      if (calm_tail && i >= count - 300) calm = 1'b1;
      send_access(random_access());
    end
    in_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    while (tracker.expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_dips(bit [7:0] one, bit [7:0] two);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIP_ONE;
    cfg_data  <= one;
    @(posedge clk);
    cfg_index <= CFG_DIP_TWO;
    cfg_data  <= two;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_dip(CFG_DIP_ONE, one);
    tracker.set_dip(CFG_DIP_TWO, two);
  endtask

  // receiver: random holds, one long hold to back the block up
  initial begin
    bit held;
    held = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      if (!held && results_seen >= 200) begin
        held = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : watch_results
    result_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.read_data     = out_bus.read_data;
      got.rom_bank      = out_bus.rom_bank;
      got.scroll_x      = out_bus.scroll_x;
      got.scroll_y      = out_bus.scroll_y;
      got.sound_latch   = out_bus.sound_latch;
      got.coin_counters = out_bus.coin_counters;
      got.sound_reset   = out_bus.sound_reset;
      got.flip_screen   = out_bus.flip_screen;
      got.char_enable   = out_bus.char_enable;
      got.sprite_bank   = out_bus.sprite_bank;
      got.bg_enable     = out_bus.bg_enable;
      got.obj_enable    = out_bus.obj_enable;
      tracker.check_word(got);
      results_seen++;
    end
  end

  initial begin
    tracker      = new();
    calm         = 1'b0;
    results_seen = 0;
    gen_bank     = 2'd0;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_DIP_ONE;
    cfg_data             <= 8'h00;
    in_bus.valid         <= 1'b0;
    in_bus.kind          <= KIND_READ;
    in_bus.address       <= '0;
    in_bus.write_data    <= '0;
    in_bus.system_in     <= '0;
    in_bus.player_one_in <= '0;
    in_bus.player_two_in <= '0;
    in_bus.vblank        <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    set_dips(8'h00, 8'hff);
    run_stream(400, 1'b0);
    set_dips(8'hff, 8'h00);
    run_stream(400, 1'b0);
    set_dips($urandom, $urandom);
    run_stream(400, 1'b0);
    set_dips($urandom, $urandom);
    run_stream(400, 1'b1);
    drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_words.size() == 0) begin
      $display("[arcade_main_bus_decoder] OK");
    end else begin
      $display("[arcade_main_bus_decoder] ERROR");
    end
    $finish;
  end

endmodule
